/* hw/rtl/tte_pkg.sv */
// Package for the timestamp text to epoch converter.
// Holds phase and controller state types, bus structs, character codes and
// the calendar tables. No dependencies.
`default_nettype none

package tte_pkg;

  localparam int FRAC_DIGITS_DEF = 6;
  localparam int FRAC_MAX        = 6;

  typedef enum logic [3:0] {
    PH_START,
    PH_TOKEN,
    PH_SPACES,
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_MINUTE,
    PH_SECOND,
    PH_FRACTION
  } phase_t;

  typedef enum logic [1:0] {
    CT_PARSE,
    CT_STAGE1,
    CT_STAGE2,
    CT_STAGE3
  } ctrl_state_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [13:0] YEAR_MIN      = 14'd1970;
  localparam logic [13:0] YEAR_MAX      = 14'd2099;
  localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
  localparam logic [31:0] SEC_PER_DAY   = 32'd86400;
  localparam logic [18:0] SEC_PER_HOUR  = 19'd3600;
  localparam logic [18:0] SEC_PER_MIN   = 19'd60;
  localparam logic [51:0] US_PER_SEC    = 52'd1000000;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [19:0] fraction;
    logic [2:0]  digit_count;
    logic        in_fraction;
  } fields_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_eor;
    logic out_busy;
  } stat_t;

  function automatic logic [24:0] month_start(input logic [3:0] idx);
    logic [24:0] s;
    case (idx)
      4'd0:    s = 25'd0;
      4'd1:    s = 25'd2678400;
      4'd2:    s = 25'd5097600;
      4'd3:    s = 25'd7776000;
      4'd4:    s = 25'd10368000;
      4'd5:    s = 25'd13046400;
      4'd6:    s = 25'd15638400;
      4'd7:    s = 25'd18316800;
      4'd8:    s = 25'd20995200;
      4'd9:    s = 25'd23587200;
      4'd10:   s = 25'd26265600;
      4'd11:   s = 25'd28857600;
      default: s = 25'd0;
    endcase
    return s;
  endfunction

  // Scale for a fraction holding dc digits up to microseconds.
  function automatic logic [19:0] frac_scale(input logic [2:0] dc);
    logic [19:0] s;
    case (dc)
      3'd0:    s = 20'd1000000;
      3'd1:    s = 20'd100000;
      3'd2:    s = 20'd10000;
      3'd3:    s = 20'd1000;
      3'd4:    s = 20'd100;
      3'd5:    s = 20'd10;
      default: s = 20'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tte_in_if.sv */
// Character input channel: valid/ready handshake with one character a transfer.
// Standalone interface, no dependencies.
`default_nettype none

interface tte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_record;

  modport source (output valid, output char_code, output end_of_record, input ready);
  modport sink (input valid, input char_code, input end_of_record, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tte_out_if.sv */
// Result channel: valid/ready handshake with one epoch value a transfer.
// Standalone interface, no dependencies.
`default_nettype none

interface tte_out_if;
  logic        valid;
  logic        ready;
  logic [51:0] epoch_us;
  logic        out_of_range;

  modport source (output valid, output epoch_us, output out_of_range, input ready);
  modport sink (input valid, input epoch_us, input out_of_range, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tte_parse.sv */
// Character parser: parse phase register and the decimal field accumulators.
// Depends on tte_pkg.
`default_nettype none

module tte_parse import tte_pkg::*; #(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       skip,
  input  logic       clear,
  output fields_t    fields
);

  localparam logic [2:0] FRAC_LIMIT =
    3'((FRAC_DIGITS < FRAC_MAX) ? FRAC_DIGITS : FRAC_MAX);

  phase_t      phase, phase_next, phase_eff, fld_phase, sep_phase;
  logic [2:0]  digit_count, dc_next, dc_base, limit;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next, day, day_next, hour, hour_next;
  logic [6:0]  minute, minute_next, second, second_next;
  logic [19:0] fraction, fraction_next;
  logic [19:0] acc_cur, acc_new;
  logic [7:0]  sep;
  logic        has_sep, is_digit, is_field, acc_wr;

  assign is_digit = char_code inside {[CH_ZERO:CH_NINE]};
  assign acc_new  = 20'(acc_cur * 20'd10) + {16'd0, char_code[3:0]};

  always_comb begin
    phase_next    = phase;
    dc_next       = digit_count;
    year_next     = year;
    month_next    = month;
    day_next      = day;
    hour_next     = hour;
    minute_next   = minute;
    second_next   = second;
    fraction_next = fraction;
    acc_wr        = 1'b0;
    phase_eff     = (phase == PH_START) ? (skip ? PH_TOKEN : PH_YEAR) : phase;
    fld_phase     = phase_eff;
    dc_base       = digit_count;
    if (phase_eff == PH_SPACES && char_code != CH_SPACE) begin
      fld_phase = PH_YEAR;
      dc_base   = 3'd0;
    end
    sep       = CH_SPACE;
    has_sep   = 1'b1;
    limit     = 3'd2;
    sep_phase = fld_phase;
    acc_cur   = 20'd0;
    case (fld_phase)
      PH_YEAR: begin
        sep = CH_DASH; limit = 3'd4; sep_phase = PH_MONTH; acc_cur = 20'(year);
      end
      PH_MONTH: begin
        sep = CH_DASH; sep_phase = PH_DAY; acc_cur = 20'(month);
      end
      PH_DAY: begin
        sep = CH_SPACE; sep_phase = PH_HOUR; acc_cur = 20'(day);
      end
      PH_HOUR: begin
        sep = CH_COLON; sep_phase = PH_MINUTE; acc_cur = 20'(hour);
      end
      PH_MINUTE: begin
        sep = CH_COLON; sep_phase = PH_SECOND; acc_cur = 20'(minute);
      end
      PH_SECOND: begin
        sep = CH_DOT; sep_phase = PH_FRACTION; acc_cur = 20'(second);
      end
      PH_FRACTION: begin
        has_sep = 1'b0; limit = FRAC_LIMIT; acc_cur = fraction;
      end
      default: ;
    endcase
    is_field = fld_phase inside {[PH_YEAR:PH_FRACTION]};

    if (accept) begin
      if (phase_eff == PH_TOKEN) begin
        phase_next = (char_code == CH_SPACE) ? PH_SPACES : PH_TOKEN;
      end else if (phase_eff == PH_SPACES && char_code == CH_SPACE) begin
        phase_next = PH_SPACES;
      end else if (is_field) begin
        phase_next = fld_phase;
        if (has_sep && char_code == sep) begin
          phase_next = sep_phase;
          dc_next    = 3'd0;
        end else if (is_digit) begin
          dc_next = dc_base;
          if (dc_base < limit) begin
            acc_wr  = 1'b1;
            dc_next = dc_base + 3'd1;
          end
        end else begin
          dc_next = limit;
        end
      end
    end

    if (acc_wr) begin
      case (fld_phase)
        PH_YEAR:     year_next     = acc_new[13:0];
        PH_MONTH:    month_next    = acc_new[6:0];
        PH_DAY:      day_next      = acc_new[6:0];
        PH_HOUR:     hour_next     = acc_new[6:0];
        PH_MINUTE:   minute_next   = acc_new[6:0];
        PH_SECOND:   second_next   = acc_new[6:0];
        PH_FRACTION: fraction_next = acc_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase       <= PH_START;
      digit_count <= 3'd0;
      year        <= 14'd0;
      month       <= 7'd0;
      day         <= 7'd0;
      hour        <= 7'd0;
      minute      <= 7'd0;
      second      <= 7'd0;
      fraction    <= 20'd0;
    end else begin
      phase       <= phase_next;
      digit_count <= dc_next;
      year        <= year_next;
      month       <= month_next;
      day         <= day_next;
      hour        <= hour_next;
      minute      <= minute_next;
      second      <= second_next;
      fraction    <= fraction_next;
    end
  end

  assign fields.year        = year;
  assign fields.month       = month;
  assign fields.day         = day;
  assign fields.hour        = hour;
  assign fields.minute      = minute;
  assign fields.second      = second;
  assign fields.fraction    = fraction;
  assign fields.digit_count = digit_count;
  assign fields.in_fraction = (phase == PH_FRACTION);

endmodule

`default_nettype wire

/* hw/rtl/tte_conv.sv */
// Conversion datapath: the s1 and s2 register stages from parsed fields to
// epoch microseconds, plus the output register. Depends on tte_pkg.
`default_nettype none

module tte_conv import tte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fields_t     fields,
  input  cmd_t        cmd,
  input  logic        out_ready,
  output logic        out_busy,
  output logic        out_valid,
  output logic [51:0] epoch_us,
  output logic        out_of_range
);

  logic [13:0] year_off;
  logic [7:0]  yoff;
  logic [6:0]  day_off;
  logic [5:0]  leap_cnt;
  logic [3:0]  m_idx;
  logic        leap, oor_c;
  logic [15:0] days_c;
  logic [18:0] hms_c;
  logic [19:0] frac_c;

  logic        s1_oor;
  logic [15:0] s1_days;
  logic [24:0] s1_mstart;
  logic [18:0] s1_hms;
  logic [19:0] s1_frac;

  logic        s2_oor;
  logic [31:0] s2_secs;
  logic [19:0] s2_frac;
  logic [51:0] us_c;

  always_comb begin
    year_off = fields.year - YEAR_MIN;
    yoff     = year_off[7:0];
    oor_c    = (fields.year < YEAR_MIN) || (fields.year > YEAR_MAX);
    if (fields.month == 7'd0) begin
      m_idx = 4'd0;
    end else if (fields.month > 7'd12) begin
      m_idx = 4'd11;
    end else begin
      m_idx = 4'(fields.month - 7'd1);
    end
    leap     = (fields.year[1:0] == 2'b00) && (fields.month > 7'd2);
    leap_cnt = 6'((yoff + 8'd1) >> 2);
    day_off  = (fields.day == 7'd0) ? 7'd0 : fields.day - 7'd1;
    days_c   = 16'(yoff) * DAYS_PER_YEAR + 16'(leap_cnt) + 16'(leap) + 16'(day_off);
    hms_c    = 19'(fields.hour) * SEC_PER_HOUR + 19'(fields.minute) * SEC_PER_MIN
             + 19'(fields.second);
    frac_c   = fields.in_fraction ?
               20'(fields.fraction * frac_scale(fields.digit_count)) : 20'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.s1_en) begin
      s1_oor    <= oor_c;
      s1_days   <= days_c;
      s1_mstart <= month_start(m_idx);
      s1_hms    <= hms_c;
      s1_frac   <= frac_c;
    end
    if (cmd.s2_en) begin
      s2_oor  <= s1_oor;
      s2_secs <= 32'(s1_days) * SEC_PER_DAY + 32'(s1_mstart) + 32'(s1_hms);
      s2_frac <= s1_frac;
    end
  end

  assign us_c = 52'(s2_secs) * US_PER_SEC + 52'(s2_frac);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      epoch_us     <= s2_oor ? 52'd0 : us_c;
      out_of_range <= s2_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

/* hw/rtl/tte_ctrl.sv */
// Controller: takes characters while parsing, then steps the conversion
// stages and loads the result once the output register is free. Uses tte_pkg.
`default_nettype none

module tte_ctrl import tte_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CT_PARSE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      CT_PARSE: begin
        in_ready = 1'b1;
        if (stat.in_valid && stat.in_eor) begin
          state_next = CT_STAGE1;
        end
      end
      CT_STAGE1: begin
        cmd.s1_en  = 1'b1;
        state_next = CT_STAGE2;
      end
      CT_STAGE2: begin
        cmd.s2_en  = 1'b1;
        state_next = CT_STAGE3;
      end
      CT_STAGE3: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = CT_PARSE;
        end
      end
      default: state_next = CT_PARSE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/timestamp_text_to_epoch_us_core.sv */
// Timestamp text to Unix epoch microseconds converter, top level.
// Depends on tte_pkg, tte_in_if, tte_out_if, tte_parse, tte_conv, tte_ctrl.
//
// Usage:
//   in_ch carries one ASCII character of a "YYYY-MM-DD HH:MM:SS.ffffff" record
//   per transfer; end_of_record marks the record's last character. out_ch
//   carries one epoch_us / out_of_range result per record.
//   cfg_wr_en / cfg_wr_data write skip_leading_token; write it only while idle.
// Flow:
//   While parsing, in_ch.ready is high and characters are taken as they come.
//   After the last character of a record the three conversion stages (field
//   sums, day-to-second multiply, second-to-microsecond multiply) run in turn,
//   during which in_ch.ready is low; the last stage loads the output register,
//   which raises out_ch.valid.
// Stall:
//   The result sits in an output register, so parsing of the next record
//   proceeds while it waits. If the register is still full when the next
//   result is ready, the block holds in its last stage with ready low.
// Reset:
//   rst clears the parser fields, the controller, the output valid and the
//   mode register (token skip off).
`default_nettype none

module timestamp_text_to_epoch_us_core import tte_pkg::*; #(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  tte_in_if.sink    in_ch,
  tte_out_if.source out_ch
);

  logic    skip;
  logic    in_ready, accept, out_busy;
  fields_t fields;
  cmd_t    cmd;
  stat_t   stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= 1'b0;
    end else if (cfg_wr_en) begin
      skip <= cfg_wr_data;
    end
  end

  assign in_ch.ready   = in_ready;
  assign accept        = in_ch.valid && in_ready;
  assign stat.in_valid = in_ch.valid;
  assign stat.in_eor   = in_ch.end_of_record;
  assign stat.out_busy = out_busy;

  tte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tte_parse #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (in_ch.char_code),
    .skip      (skip),
    .clear     (cmd.clear),
    .fields    (fields)
  );

  tte_conv u_conv (
    .clk          (clk),
    .rst          (rst),
    .fields       (fields),
    .cmd          (cmd),
    .out_ready    (out_ch.ready),
    .out_busy     (out_busy),
    .out_valid    (out_ch.valid),
    .epoch_us     (out_ch.epoch_us),
    .out_of_range (out_ch.out_of_range)
  );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Testbench for timestamp_text_to_epoch_us_core: streams timestamp text records in,
// predicts each epoch result and checks the result channel transfer by transfer.
// Depends on tte_pkg, tte_in_if, tte_out_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import tte_pkg::*;

  localparam int unsigned FRAC_KEEP    = (FRAC_DIGITS_DEF < 6) ? FRAC_DIGITS_DEF : 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [51:0] epoch_us;
    logic        out_of_range;
  } epoch_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  tte_in_if  in_ch ();
  tte_out_if out_ch ();

  timestamp_text_to_epoch_us_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Shadow of the parser state
  logic        skip_mode;
  phase_t      phase;
  int unsigned digits;
  int unsigned year_acc, month_acc, day_acc, hour_acc, minute_acc, second_acc, frac_acc;

  epoch_result_t pending_epochs[$];
  epoch_result_t want;
  logic [7:0]    rec[$];

  int unsigned chars_taken = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned src_idle    = 0;
  int unsigned snk_idle    = 0;
  logic        rx_hold     = 1'b0;

  function automatic void clear_fields();
    phase      = PH_START;
    digits     = 0;
    year_acc   = 0;
    month_acc  = 0;
    day_acc    = 0;
    hour_acc   = 0;
    minute_acc = 0;
    second_acc = 0;
    frac_acc   = 0;
  endfunction

  function automatic int unsigned accum(input int unsigned acc, input int unsigned lim,
                                        input logic [7:0] ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (digits < lim) begin
        digits++;
        return acc * 10 + 32'(ch - CH_ZERO);
      end
    end else begin
      digits = lim;
    end
    return acc;
  endfunction

  function automatic void take_field(input logic [7:0] ch);
    case (phase)
      PH_YEAR: begin
        if (ch == CH_DASH) begin
          phase = PH_MONTH;
          digits = 0;
        end else year_acc = accum(year_acc, 4, ch);
      end
      PH_MONTH: begin
        if (ch == CH_DASH) begin
          phase = PH_DAY;
          digits = 0;
        end else month_acc = accum(month_acc, 2, ch);
      end
      PH_DAY: begin
        if (ch == CH_SPACE) begin
          phase = PH_HOUR;
          digits = 0;
        end else day_acc = accum(day_acc, 2, ch);
      end
      PH_HOUR: begin
        if (ch == CH_COLON) begin
          phase = PH_MINUTE;
          digits = 0;
        end else hour_acc = accum(hour_acc, 2, ch);
      end
      PH_MINUTE: begin
        if (ch == CH_COLON) begin
          phase = PH_SECOND;
          digits = 0;
        end else minute_acc = accum(minute_acc, 2, ch);
      end
      PH_SECOND: begin
        if (ch == CH_DOT) begin
          phase = PH_FRACTION;
          digits = 0;
        end else second_acc = accum(second_acc, 2, ch);
      end
      PH_FRACTION: frac_acc = accum(frac_acc, FRAC_KEEP, ch);
      default: ;
    endcase
  endfunction

  function automatic int unsigned month_len(input int unsigned m);
    case (m)
      2: return 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic epoch_result_t epoch_from_fields();
    epoch_result_t r;
    int unsigned   m;
    logic [63:0]   days;
    logic [63:0]   secs;
    logic [63:0]   frac;
    r.epoch_us = '0;
    r.out_of_range = 1'b0;
    if (year_acc < 32'(YEAR_MIN) || year_acc > 32'(YEAR_MAX)) begin
      r.out_of_range = 1'b1;
      return r;
    end
    m = (month_acc < 1) ? 1 : (month_acc > 12) ? 12 : month_acc;
    days = 64'(365 * (year_acc - 1970) + (year_acc - 1969) / 4);
    if (year_acc % 4 == 0 && m > 2) days += 64'd1;
    if (day_acc > 0) days += 64'(day_acc - 1);
    for (int i = 1; i < m; i++) days += 64'(month_len(i));
    secs = days * 64'd86400 + 64'(hour_acc) * 64'd3600 + 64'(minute_acc) * 64'd60
         + 64'(second_acc);
    frac = 64'(frac_acc);
    for (int i = digits; i < 6; i++) frac *= 64'd10;
    if (phase != PH_FRACTION) frac = 64'd0;
    r.epoch_us = 52'(secs * 64'd1000000 + frac);
    return r;
  endfunction

  function automatic void parse_char(input logic [7:0] ch, input logic last);
    if (phase == PH_START) phase = skip_mode ? PH_TOKEN : PH_YEAR;
    if (phase == PH_TOKEN) begin
      if (ch == CH_SPACE) phase = PH_SPACES;
    end else if (phase == PH_SPACES) begin
      if (ch != CH_SPACE) begin
        phase = PH_YEAR;
        digits = 0;
        take_field(ch);
      end
    end else begin
      take_field(ch);
    end
    if (last) begin
      pending_epochs.push_back(epoch_from_fields());
      clear_fields();
    end
  endfunction

  function automatic void report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL timestamp_text_to_epoch_us_core");
      $finish;
    end else if (rst) begin
      skip_mode = 1'b0;
      clear_fields();
    end else begin
      if (cfg_wr_en) skip_mode = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) begin
        chars_taken++;
        parse_char(in_ch.char_code, in_ch.end_of_record);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_epochs.size() == 0) begin
          report($sformatf("unexpected result: epoch_us=%0d out_of_range=%0b",
                           out_ch.epoch_us, out_ch.out_of_range));
        end else begin
          want = pending_epochs.pop_front();
          if (out_ch.epoch_us !== want.epoch_us)
            report($sformatf("epoch_us mismatch: expected %0d, got %0d",
                             want.epoch_us, out_ch.epoch_us));
          if (out_ch.out_of_range !== want.out_of_range)
            report($sformatf("out_of_range mismatch: expected %0b, got %0b",
                             want.out_of_range, out_ch.out_of_range));
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    int unsigned taken;
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_code     <= ch;
    in_ch.end_of_record <= last;
    taken = chars_taken;
    do @(negedge clk); while (chars_taken == taken);
  endtask

  task automatic send_rec();
    for (int i = 0; i < rec.size(); i++) send_char(rec[i], i == rec.size() - 1);
    rec.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rec.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_rec();
  endtask

  task automatic push_num(input int unsigned v, input int unsigned nd);
    int unsigned div;
    div = 1;
    repeat (nd - 1) div *= 10;
    repeat (nd) begin
      rec.push_back(CH_ZERO + 8'((v / div) % 10));
      div /= 10;
    end
  endtask

  function automatic int unsigned field_width();
    return ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 2;
  endfunction

  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
    return ($urandom_range(9) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
  endfunction

  task automatic build_record(input logic skip);
    int unsigned n;
    int unsigned yr;
    if (skip) begin
      repeat ($urandom_range(1, 6)) rec.push_back(8'($urandom_range(33, 255)));
      n = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4);
      repeat (n) rec.push_back(CH_SPACE);
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30)) rec.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(5))
      0: yr = $urandom_range(0, 9999);
      1: yr = $urandom_range(1) ? 1969 : 2100;
      default: yr = $urandom_range(1970, 2099);
    endcase
    push_num(yr, ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 4);
    rec.push_back(CH_DASH);
    push_num(pick(1, 12), field_width());
    rec.push_back(CH_DASH);
    push_num(pick(1, 31), field_width());
    rec.push_back(CH_SPACE);
    push_num(pick(0, 23), field_width());
    rec.push_back(CH_COLON);
    push_num(pick(0, 59), field_width());
    rec.push_back(CH_COLON);
    push_num(pick(0, 59), field_width());
    if ($urandom_range(5) != 0) begin
      rec.push_back(CH_DOT);
      repeat ($urandom_range(0, 9)) rec.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    if ($urandom_range(7) == 0)
      rec[$urandom_range(rec.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(1, 4)) rec.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(1, rec.size());
      while (rec.size() > n) void'(rec.pop_back());
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_epochs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wr_data <= m;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic test_plain_directed();
    src_idle = 0;
    snk_idle = 0;
    send_text("1970-01-01 00:00:00.000000");
    send_text("2099-12-31 23:59:59.999999");
    send_text("1969-12-31 23:59:59");
    send_text("2100-01-01 00:00:00");
    send_text("2000-02-29 12:00:00.5");
    send_text("2024-03-01 00:00:00.1234567");
    send_text("2023-00-00 99:99:99");
    send_text("2023-13-05 07:08:09.25");
    send_text("20245-1");
    send_text("2021-4x5-06 10:1y1:02.3z4");
    send_text("2021-06-15 08:30:00.123456 UTC");
    send_text("2004-2-9 1:2:3");
    send_text("7");
    push_text("2050-");
    rec.push_back(8'hFF);
    rec.push_back(8'h00);
    push_text("1-02 03:04:05.6");
    send_rec();
    drain();
  endtask

  task automatic test_token_directed();
    write_mode(1'b1);
    send_text("host   2021-06-15 08:30:00.25");
    send_text("x 1970-01-01 00:00:00.0");
    send_text(" 2000-01-01 00:00:00");
    send_text("noSpaceHere");
    send_text("tok    ");
    drain();
  endtask

  task automatic test_random(input logic skip, input int unsigned src, input int unsigned snk,
                             input int unsigned n_chars);
    int unsigned sent;
    write_mode(skip);
    src_idle = src;
    snk_idle = snk;
    sent = 0;
    while (sent < n_chars) begin
      build_record(skip);
      sent += rec.size();
      send_rec();
    end
    drain();
  endtask

  task automatic test_output_stall();
    src_idle = 0;
    snk_idle = 0;
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (10) begin
      build_record(skip_mode);
      send_rec();
    end
    drain();
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.char_code     = '0;
    in_ch.end_of_record = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_plain_directed();
    test_token_directed();
    test_random(1'b0, 11, 49, 350);
    test_random(1'b1, 49, 11, 350);
    test_random(1'b0, 0, 0, 150);
    test_random(1'b1, 0, 0, 100);
    test_output_stall();
    if (mismatches == 0) begin
      $display("PASS timestamp_text_to_epoch_us_core");
    end else begin
      $display("FAIL timestamp_text_to_epoch_us_core");
    end
    $finish;
  end

endmodule
